### hw/rtl/ibmd_pkg.sv
// Shared types, register indexes and default sizes for the block-mean downsampler.
// No dependencies; every other file imports this package.
package ibmd_pkg;

   // default sizes handed to the top-level parameters
   localparam int DEF_MAX_DIM      = 4096;
   localparam int DEF_MAX_OUT_SIZE = 300;
   localparam int DEF_PIXEL_BITS   = 16;

   // fixed field widths of the ports
   localparam int CFG_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int VALUE_W     = 16;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_FULL_RES     = 2'd2
   } csr_index_type;

   // input item
   typedef struct packed {
      logic               frame_start;
      logic [VALUE_W-1:0] pixel_value;
   } req_type;

   // result item
   typedef struct packed {
      logic [VALUE_W-1:0] mean_value;
      logic               row_end;
      logic               frame_end;
   } rsp_type;

   // per-pixel control flags from front to back
   typedef struct packed {
      logic first;
      logic done;
      logic row_end;
      logic frame_end;
   } ctrl_type;

   localparam int CTRL_W = $bits(ctrl_type);

   typedef enum logic [0:0] {
      F_RUN,
      F_SETUP
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_ACC,
      B_DIV,
      B_SEND
   } back_state_type;

endpackage

### hw/rtl/ibmd_queue.sv
// Small flop-based FIFO between the front and back parts.
// Depends on ibmd_pkg for the default depth.
module ibmd_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = ibmd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              not_empty
);
   import ibmd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/ibmd_front.sv
// Front part: configuration registers, frame setup (shrink factor) and raster
// classification of each pixel into block position and flags. Uses ibmd_pkg.
module ibmd_front #(
   parameter int MAX_DIM      = ibmd_pkg::DEF_MAX_DIM,
   parameter int MAX_OUT_SIZE = ibmd_pkg::DEF_MAX_OUT_SIZE,
   parameter int PIXEL_BITS   = ibmd_pkg::DEF_PIXEL_BITS,
   parameter int FW           = 4,
   parameter int IW           = 9,
   parameter int QW           = 33
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ibmd_pkg::req_type                   req_data,
   input  logic                                csr_valid,
   input  logic [ibmd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ibmd_pkg::CFG_DATA_W-1:0]     csr_data,
   output logic                                push,
   output logic [QW-1:0]                       push_data,
   input  logic                                queue_full
);
   import ibmd_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int OW    = $clog2(MAX_OUT_SIZE + 1);
   localparam int RW    = (DIM_W > OW) ? DIM_W : OW;
   localparam int EW    = DIM_W + 2;

   // configuration registers
   logic [CFG_DATA_W-1:0] cfg_w_ff, cfg_h_ff;
   logic                  cfg_full_ff;

   // frame setup and raster state
   front_state_type       state_ff, state_in;
   logic [DIM_W-1:0]      frame_w_ff, frame_w_in, frame_h_ff, frame_h_in;
   logic [FW-1:0]         factor_ff, factor_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [PIXEL_BITS-1:0] held_ff, held_in;
   logic                  active_ff, active_in;
   logic [DIM_W-1:0]      in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [FW-1:0]         sub_col_ff, sub_col_in, sub_row_ff, sub_row_in;
   logic [DIM_W-1:0]      block_col_ff, block_col_in;
   logic [DIM_W-1:0]      col_base_ff, col_base_in, row_base_ff, row_base_in;

   logic [DIM_W-1:0]      clamp_w, clamp_h;
   logic                  accept;
   logic                  proc;
   logic [PIXEL_BITS-1:0] cur_pix;
   logic [EW-1:0]         f_ext, fw_ext, fh_ext, cb_ext, rb_ext;
   logic                  in_range;
   ctrl_type              ctrl;
   logic [IW-1:0]         idx;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff    <= CFG_DATA_W'(256);
         cfg_h_ff    <= CFG_DATA_W'(256);
         cfg_full_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_w_ff    <= csr_data;
            CSR_IMAGE_HEIGHT: cfg_h_ff    <= csr_data;
            CSR_FULL_RES:     cfg_full_ff <= csr_data[0];
            default:          ;
         endcase
      end
   end

   assign clamp_w   = clamp_dim(cfg_w_ff);
   assign clamp_h   = clamp_dim(cfg_h_ff);
   assign req_ready = (state_ff == F_RUN) && !queue_full;
   assign accept    = req_valid && req_ready;

   // block coverage tests without division: block fits when base + f <= size
   assign f_ext  = EW'(factor_ff);
   assign fw_ext = EW'(frame_w_ff);
   assign fh_ext = EW'(frame_h_ff);
   assign cb_ext = EW'(col_base_ff);
   assign rb_ext = EW'(row_base_ff);
   assign in_range = (cb_ext + f_ext <= fw_ext) && (rb_ext + f_ext <= fh_ext);

   always_comb begin
      ctrl.first     = (sub_row_ff == '0) && (sub_col_ff == '0);
      ctrl.done      = (sub_row_ff == factor_ff - 1'b1) && (sub_col_ff == factor_ff - 1'b1);
      ctrl.row_end   = (cb_ext + (f_ext << 1)) > fw_ext;
      ctrl.frame_end = ctrl.row_end && ((rb_ext + (f_ext << 1)) > fh_ext);
      if (int'(block_col_ff) >= MAX_OUT_SIZE) begin
         idx = IW'(MAX_OUT_SIZE - 1);
      end else begin
         idx = IW'(block_col_ff);
      end
   end

   // next state: frame setup, classification and raster advance
   always_comb begin
      state_in     = state_ff;
      frame_w_in   = frame_w_ff;
      frame_h_in   = frame_h_ff;
      factor_in    = factor_ff;
      rem_in       = rem_ff;
      held_in      = held_ff;
      active_in    = active_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      sub_col_in   = sub_col_ff;
      sub_row_in   = sub_row_ff;
      block_col_in = block_col_ff;
      col_base_in  = col_base_ff;
      row_base_in  = row_base_ff;
      proc         = 1'b0;
      cur_pix      = PIXEL_BITS'(req_data.pixel_value);

      case (state_ff)
         F_RUN: begin
            if (accept && req_data.frame_start) begin
               // latch window size and start the factor search
               state_in     = F_SETUP;
               frame_w_in   = clamp_w;
               frame_h_in   = clamp_h;
               factor_in    = FW'(1);
               if (cfg_full_ff) begin
                  rem_in = '0;
               end else begin
                  rem_in = RW'((clamp_w > clamp_h) ? clamp_w : clamp_h);
               end
               held_in      = PIXEL_BITS'(req_data.pixel_value);
               active_in    = 1'b1;
               in_col_in    = '0;
               in_row_in    = '0;
               sub_col_in   = '0;
               sub_row_in   = '0;
               block_col_in = '0;
               col_base_in  = '0;
               row_base_in  = '0;
            end else if (accept && active_ff) begin
               proc = 1'b1;
            end
         end
         F_SETUP: begin
            cur_pix = held_ff;
            if (rem_ff >= RW'(MAX_OUT_SIZE)) begin
               // one subtraction of the output limit per cycle
               rem_in    = rem_ff - RW'(MAX_OUT_SIZE);
               factor_in = factor_ff + 1'b1;
            end else if (!queue_full) begin
               proc     = 1'b1;
               state_in = F_RUN;
            end
         end
         default: state_in = F_RUN;
      endcase

      // raster counters
      if (proc) begin
         if (EW'(in_col_ff) + EW'(1) >= fw_ext) begin
            in_col_in    = '0;
            sub_col_in   = '0;
            block_col_in = '0;
            col_base_in  = '0;
            if (sub_row_ff + 1'b1 >= factor_ff) begin
               sub_row_in  = '0;
               row_base_in = row_base_ff + DIM_W'(factor_ff);
            end else begin
               sub_row_in = sub_row_ff + 1'b1;
            end
            in_row_in = in_row_ff + 1'b1;
            if (EW'(in_row_ff) + EW'(1) >= fh_ext) begin
               active_in   = 1'b0;
               in_row_in   = '0;
               sub_row_in  = '0;
               row_base_in = '0;
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
            if (sub_col_ff + 1'b1 >= factor_ff) begin
               sub_col_in   = '0;
               block_col_in = block_col_ff + 1'b1;
               col_base_in  = col_base_ff + DIM_W'(factor_ff);
            end else begin
               sub_col_in = sub_col_ff + 1'b1;
            end
         end
      end
   end

   assign push      = proc && in_range;
   assign push_data = {cur_pix, factor_ff, idx, ctrl};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_RUN;
         frame_w_ff   <= DIM_W'(1);
         frame_h_ff   <= DIM_W'(1);
         factor_ff    <= FW'(1);
         rem_ff       <= '0;
         active_ff    <= 1'b0;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         sub_col_ff   <= '0;
         sub_row_ff   <= '0;
         block_col_ff <= '0;
         col_base_ff  <= '0;
         row_base_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         frame_w_ff   <= frame_w_in;
         frame_h_ff   <= frame_h_in;
         factor_ff    <= factor_in;
         rem_ff       <= rem_in;
         active_ff    <= active_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         sub_col_ff   <= sub_col_in;
         sub_row_ff   <= sub_row_in;
         block_col_ff <= block_col_in;
         col_base_ff  <= col_base_in;
         row_base_ff  <= row_base_in;
      end
   end

   // held frame-start pixel
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

### hw/rtl/ibmd_back.sv
// Back part: column sum memory, block accumulation, serial mean divider and
// result register. Uses ibmd_pkg.
module ibmd_back #(
   parameter int MAX_OUT_SIZE = ibmd_pkg::DEF_MAX_OUT_SIZE,
   parameter int PIXEL_BITS   = ibmd_pkg::DEF_PIXEL_BITS,
   parameter int FW           = 4,
   parameter int IW           = 9,
   parameter int QW           = 33
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  logic [QW-1:0]     q_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ibmd_pkg::rsp_type rsp_data
);
   import ibmd_pkg::*;

   localparam int DW    = 2 * FW;
   localparam int SUM_W = PIXEL_BITS + DW;
   localparam int CNT_W = $clog2(SUM_W + 1);

   // queue entry fields
   logic [PIXEL_BITS-1:0] e_pix;
   logic [FW-1:0]         e_factor;
   logic [IW-1:0]         e_idx;
   ctrl_type              e_ctrl;

   assign e_pix    = q_data[QW-1 -: PIXEL_BITS];
   assign e_factor = q_data[CTRL_W + IW +: FW];
   assign e_idx    = q_data[CTRL_W +: IW];
   assign e_ctrl   = q_data[CTRL_W-1:0];

   back_state_type        state_ff, state_in;
   logic [PIXEL_BITS-1:0] pix_ff, pix_in;
   logic [FW-1:0]         factor_ff, factor_in;
   logic [IW-1:0]         idx_ff, idx_in;
   ctrl_type              ctrl_ff, ctrl_in;
   logic [SUM_W-1:0]      num_ff, num_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [DW-1:0]         div_ff, div_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // column sum memory
   logic [SUM_W-1:0]      sums_mem [MAX_OUT_SIZE];
   logic [SUM_W-1:0]      rdata_ff;
   logic                  mem_we, mem_re;
   logic [IW-1:0]         mem_waddr;
   logic [SUM_W-1:0]      mem_wdata;

   logic                  rsp_free;
   logic [SUM_W-1:0]      acc_sum;
   logic [DW:0]           trial;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign acc_sum   = rdata_ff + SUM_W'(pix_ff);
   assign trial     = {rem_ff, num_ff[SUM_W-1]};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      factor_in    = factor_ff;
      idx_in       = idx_ff;
      ctrl_in      = ctrl_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = e_idx;
      mem_wdata    = SUM_W'(e_pix);

      case (state_ff)
         B_IDLE: begin
            if (q_not_empty) begin
               if (e_factor == FW'(1)) begin
                  // pass-through pixel straight to the result register
                  if (rsp_free) begin
                     pop                   = 1'b1;
                     rsp_valid_in          = 1'b1;
                     rsp_data_in.mean_value = VALUE_W'(e_pix);
                     rsp_data_in.row_end   = e_ctrl.row_end;
                     rsp_data_in.frame_end = e_ctrl.frame_end;
                  end
               end else begin
                  pop       = 1'b1;
                  pix_in    = e_pix;
                  factor_in = e_factor;
                  idx_in    = e_idx;
                  ctrl_in   = e_ctrl;
                  if (e_ctrl.first) begin
                     // first pixel of a block opens its column sum
                     mem_we = 1'b1;
                  end else begin
                     mem_re   = 1'b1;
                     state_in = B_ACC;
                  end
               end
            end
         end
         B_ACC: begin
            // read-modify-write of the column sum
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = acc_sum;
            if (ctrl_ff.done) begin
               num_in   = acc_sum;
               rem_in   = '0;
               div_in   = factor_ff * factor_ff;
               cnt_in   = CNT_W'(SUM_W);
               state_in = B_DIV;
            end else begin
               state_in = B_IDLE;
            end
         end
         B_DIV: begin
            // restoring division, one quotient bit per cycle
            if (trial >= {1'b0, div_ff}) begin
               rem_in = DW'(trial - {1'b0, div_ff});
               num_in = {num_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = DW'(trial);
               num_in = {num_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = B_SEND;
            end
         end
         B_SEND: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.mean_value = VALUE_W'(num_ff);
               rsp_data_in.row_end    = ctrl_ff.row_end;
               rsp_data_in.frame_end  = ctrl_ff.frame_end;
               state_in               = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      factor_ff   <= factor_in;
      idx_ff      <= idx_in;
      ctrl_ff     <= ctrl_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= sums_mem[e_idx];
      end
   end

endmodule

### hw/rtl/image_block_mean_downsampler_unit.sv
// Top level of the block-mean downsampler: front classifier, queue and back end.
// Depends on ibmd_pkg, ibmd_front, ibmd_queue and ibmd_back.
//
// The block takes one pixel per cycle while its four-entry queue has room. A frame
// start pixel holds the input while the shrink-factor search subtracts MAX_OUT_SIZE
// from max(width, height) until the remainder falls below it (no subtraction in
// full-resolution mode), then until the queue has room to pass the pixel on. In
// the back end a factor-one pixel goes straight to the result register, the first
// pixel of a block opens its column sum, every further one reads the column-sum
// memory and then writes it back, and the last pixel of a block runs the serial
// mean divider over PIXEL_BITS + 2*ceil(log2(max factor + 1)) quotient bits, then
// loads the result register. The column-sum memory needs no clearing after reset.
module image_block_mean_downsampler_unit #(
   parameter int MAX_DIM      = ibmd_pkg::DEF_MAX_DIM,
   parameter int MAX_OUT_SIZE = ibmd_pkg::DEF_MAX_OUT_SIZE,
   parameter int PIXEL_BITS   = ibmd_pkg::DEF_PIXEL_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ibmd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ibmd_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ibmd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ibmd_pkg::CFG_DATA_W-1:0]  csr_data
);
   import ibmd_pkg::*;

   localparam int FW = $clog2(MAX_DIM / MAX_OUT_SIZE + 2);
   localparam int IW = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1;
   localparam int QW = PIXEL_BITS + FW + IW + CTRL_W;

   logic          push, queue_full, pop, q_not_empty;
   logic [QW-1:0] push_data, pop_data;

   assign csr_ready = 1'b1;

   ibmd_front #(
      .MAX_DIM(MAX_DIM), .MAX_OUT_SIZE(MAX_OUT_SIZE), .PIXEL_BITS(PIXEL_BITS),
      .FW(FW), .IW(IW), .QW(QW)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .push(push), .push_data(push_data), .queue_full(queue_full)
   );

   ibmd_queue #(
      .DATA_W(QW), .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(queue_full),
      .pop(pop), .pop_data(pop_data), .not_empty(q_not_empty)
   );

   ibmd_back #(
      .MAX_OUT_SIZE(MAX_OUT_SIZE), .PIXEL_BITS(PIXEL_BITS),
      .FW(FW), .IW(IW), .QW(QW)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_not_empty(q_not_empty), .q_data(pop_data), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

### hw/rtl/ibmd_checker.sv
// Port-level checks for the downsampler top level, plus the bind that attaches them.
// Depends on ibmd_pkg and image_block_mean_downsampler_unit.
module ibmd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ibmd_pkg::rsp_type rsp_data
);
   import ibmd_pkg::*;

   // a stalled result transfer stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // the frame's last pixel also ends its row
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.row_end)
      else $error("frame end without row end");

endmodule

bind image_block_mean_downsampler_unit ibmd_checker u_ibmd_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
